### hw/rtl/hlsrv_pkg.sv
`timescale 1ns / 1ps

package hlsrv_pkg;

	// Fixed widths of the channel fields.
	localparam int SAMPLE_FIELD_W = 10;
	localparam int WIPER_W        = 8;
	localparam int UOFF_W         = 13;
	localparam int ERR_W          = 14;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FLOOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_STEP    = 3'd4;

	// Wiper limits.
	localparam logic [WIPER_W-1:0] WIPER_MAX   = 8'd255;
	localparam logic [WIPER_W-1:0] WIPER_RESET = 8'd128;

	// Saturation bounds.
	localparam logic signed [UOFF_W-1:0] UOFF_MIN = -13'sd4096;
	localparam logic signed [UOFF_W-1:0] UOFF_MAX = 13'sd4095;
	localparam logic signed [ERR_W-1:0]  ERR_MIN  = -14'sd8192;
	localparam logic signed [ERR_W-1:0]  ERR_MAX  = 14'sd8191;

	// Extra offset steps after a raise or lower near the opposite bound.
	localparam int RETRY_LIMIT = 10;
	localparam int RETRY_W     = 4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RAISE = 2'd1,
		OP_LOWER = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_DEC  = 2'd1,
		ACT_INC  = 2'd2
	} action_t;

	typedef struct packed {
		logic [9:0]        headroom_limit;
		logic [9:0]        output_floor;
		logic signed [10:0] default_offset;
		logic [7:0]        deadband;
		logic [7:0]        offset_step;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		headroom_limit: 10'd140,
		output_floor:   10'd140,
		default_offset: 11'sd0,
		deadband:       8'd5,
		offset_step:    8'd19
	};

	// Sequencer controls shared by the three averaging lanes.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic acc_clr;
		logic mul_en;
		logic avg_en;
	} lane_ctl_t;

	// Sequencer controls for the merge stage.
	typedef struct packed {
		logic    start;
		logic    decide;
		logic    cmd;
		logic    retry;
		opcode_t op;
	} merge_ctl_t;

endpackage

### hw/rtl/hlsrv_in_if.sv
`timescale 1ns / 1ps

interface hlsrv_in_if import hlsrv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	opcode_t                   opcode;
	logic [SAMPLE_FIELD_W-1:0] ref_sample;
	logic [SAMPLE_FIELD_W-1:0] sensor_sample;
	logic [SAMPLE_FIELD_W-1:0] check_sample;

	modport source (
		output valid, opcode, ref_sample, sensor_sample, check_sample,
		input  ready
	);
	modport sink (
		input  valid, opcode, ref_sample, sensor_sample, check_sample,
		output ready
	);
endinterface

### hw/rtl/hlsrv_out_if.sv
`timescale 1ns / 1ps

interface hlsrv_out_if import hlsrv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [WIPER_W-1:0]        wiper;
	action_t                   wiper_action;
	logic                      averages_ready;
	logic signed [UOFF_W-1:0]  user_offset_now;
	logic signed [ERR_W-1:0]   control_error;

	modport source (
		output valid, wiper, wiper_action, averages_ready, user_offset_now, control_error,
		input  ready
	);
	modport sink (
		input  valid, wiper, wiper_action, averages_ready, user_offset_now, control_error,
		output ready
	);
endinterface

### hw/rtl/hlsrv_ram.sv
`timescale 1ns / 1ps

module hlsrv_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 10,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### hw/rtl/hlsrv_lane.sv
`timescale 1ns / 1ps

module hlsrv_lane import hlsrv_pkg::*; #(
	parameter int AVG_DEPTH = 10,
	parameter int SAMPLE_W  = 10,
	localparam int ADDR_W = $clog2(AVG_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctl_t           ctl,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [SAMPLE_W-1:0] sample,
	output logic [SAMPLE_W-1:0] average
);

	// The sum of all entries needs SUM_W bits; the average is the sum times a
	// rounded-up reciprocal, shifted right. This is exact for every sum below
	// 2**SUM_W.
	localparam int SUM_W   = SAMPLE_W + $clog2(AVG_DEPTH);
	localparam int SHIFT   = SUM_W + $clog2(AVG_DEPTH);
	localparam int MAGIC_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + MAGIC_W;
	localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_W'((1 << SHIFT) / AVG_DEPTH + 1);

	logic [SAMPLE_W-1:0] rdata;
	logic                rd_valid_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_s2;
	logic [SAMPLE_W-1:0] avg_q;

	hlsrv_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (AVG_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ctl.wr_en),
		.re    (ctl.rd_en),
		.addr  (addr),
		.wdata (sample),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			avg_q       <= '0;
		end else begin
			rd_valid_s1 <= ctl.rd_en;
			if (ctl.avg_en) begin
				avg_q <= prod_s2[SHIFT +: SAMPLE_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			sum_q <= '0;
		end else if (rd_valid_s1) begin
			sum_q <= sum_q + SUM_W'(rdata);
		end
		if (ctl.mul_en) begin
			prod_s2 <= PROD_W'(sum_q) * PROD_W'(MAGIC);
		end
	end

	assign average = avg_q;

endmodule

### hw/rtl/hlsrv_merge.sv
`timescale 1ns / 1ps

module hlsrv_merge import hlsrv_pkg::*; #(
	parameter int SAMPLE_W = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  merge_ctl_t               ctl,
	input  cfg_t                     cfg,
	input  logic [SAMPLE_W-1:0]      ref_avg,
	input  logic [SAMPLE_W-1:0]      sens_avg,
	input  logic [SAMPLE_W-1:0]      chk_avg,
	output logic [WIPER_W-1:0]       wiper,
	output action_t                  action,
	output logic signed [UOFF_W-1:0] user_offset,
	output logic signed [ERR_W-1:0]  ctrl_err
);

	function automatic logic signed [UOFF_W-1:0] sat_uoff(input logic signed [UOFF_W:0] v);
		if (v > (UOFF_W + 1)'(UOFF_MAX)) begin
			return UOFF_MAX;
		end else if (v < (UOFF_W + 1)'(UOFF_MIN)) begin
			return UOFF_MIN;
		end
		return UOFF_W'(v);
	endfunction

	logic [WIPER_W-1:0]       wiper_q;
	action_t                  action_q;
	logic signed [UOFF_W-1:0] uoff_q;
	logic                     retry_en_q;
	logic                     retry_up_q;

	logic signed [11:0]       ref_s, sens_s, chk_s, margin, chk_room;
	logic signed [12:0]       head_room;
	logic                     head_ok, floor_ok, near_raise, near_lower;
	logic signed [ERR_W:0]    err_raw, err_w, db_w;
	logic signed [UOFF_W-1:0] uoff_plus, uoff_minus;

	always_comb begin
		ref_s     = $signed(12'(ref_avg));
		sens_s    = $signed(12'(sens_avg));
		chk_s     = $signed(12'(chk_avg));
		margin    = ref_s - chk_s;
		head_ok   = margin >= $signed(12'(cfg.headroom_limit));
		floor_ok  = chk_s >= $signed(12'(cfg.output_floor));
		chk_room  = chk_s - $signed(12'(cfg.output_floor));
		head_room = 13'(margin) - $signed(13'(cfg.headroom_limit));
		// A raise or lower close to the opposite bound gets the extra steps.
		near_raise = chk_room < $signed(12'(cfg.offset_step));
		near_lower = head_room < $signed(13'(cfg.offset_step));

		err_raw = (ERR_W + 1)'(sens_s) - (ERR_W + 1)'(chk_s)
			+ (ERR_W + 1)'(cfg.default_offset) + (ERR_W + 1)'(uoff_q);
		if (err_raw > (ERR_W + 1)'(ERR_MAX)) begin
			ctrl_err = ERR_MAX;
		end else if (err_raw < (ERR_W + 1)'(ERR_MIN)) begin
			ctrl_err = ERR_MIN;
		end else begin
			ctrl_err = ERR_W'(err_raw);
		end
		err_w = (ERR_W + 1)'(ctrl_err);
		db_w  = $signed((ERR_W + 1)'(cfg.deadband));

		uoff_plus  = sat_uoff((UOFF_W + 1)'(uoff_q) + $signed((UOFF_W + 1)'(cfg.offset_step)));
		uoff_minus = sat_uoff((UOFF_W + 1)'(uoff_q) - $signed((UOFF_W + 1)'(cfg.offset_step)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiper_q    <= WIPER_RESET;
			action_q   <= ACT_NONE;
			uoff_q     <= '0;
			retry_en_q <= 1'b0;
			retry_up_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				action_q   <= ACT_NONE;
				retry_en_q <= 1'b0;
			end
			if (ctl.decide) begin
				if (err_w < 0 && wiper_q != '0 && floor_ok) begin
					if (err_w < -db_w) begin
						wiper_q  <= wiper_q - WIPER_W'(1);
						action_q <= ACT_DEC;
					end
				end else if (err_w > 0 && wiper_q != WIPER_MAX && head_ok) begin
					if (err_w > db_w) begin
						wiper_q  <= wiper_q + WIPER_W'(1);
						action_q <= ACT_INC;
					end
				end
			end
			if (ctl.cmd) begin
				case (ctl.op)
					OP_RAISE: begin
						if (head_ok) begin
							uoff_q     <= uoff_plus;
							retry_en_q <= near_raise;
							retry_up_q <= 1'b1;
						end
					end
					OP_LOWER: begin
						if (floor_ok) begin
							uoff_q     <= uoff_minus;
							retry_en_q <= near_lower;
							retry_up_q <= 1'b0;
						end
					end
					OP_CLEAR: begin
						uoff_q <= '0;
					end
					default: begin
					end
				endcase
			end
			// Once the error has crossed zero the offset stops moving, so later
			// steps leave it alone without an explicit exit.
			if (ctl.retry && retry_en_q) begin
				if (retry_up_q && err_w < 0) begin
					uoff_q <= uoff_plus;
				end else if (!retry_up_q && err_w > 0) begin
					uoff_q <= uoff_minus;
				end
			end
		end
	end

	assign wiper       = wiper_q;
	assign action      = action_q;
	assign user_offset = uoff_q;

endmodule

### hw/rtl/headlamp_level_servo_core.sv
`timescale 1ns / 1ps

// Headlamp level servo core.
// Items arrive on the cmd channel (valid/ready): a sample tick carrying the
// reference, sensor and check ADC readings, or a raise, lower or clear of the
// user offset. Every item gives exactly one result on the result channel:
// wiper position, wiper action, ring-full flag, user offset and control error.
// Configuration registers are written through cfg_write_en/cfg_index/cfg_data.
// The user must write them only while the block is idle; the block itself does
// not enforce this. An index beyond the register list is ignored. A tick while
// the rings are still filling goes straight to the finishing step; once they
// are full a tick first runs the sweep that reads each ring entry one per cycle,
// then the drain, multiply, divide and decide steps. A clear runs the command
// step, a raise or lower the command step and then the offset retry steps. One
// item is in work at a time; a new item is taken the cycle after the result is loaded.
// The result register parts the two sides: a stalled receiver holds only the
// finishing step of the next item. Reset clears the rings' fill state, the
// averages and the user offset, puts the wiper at mid scale and loads the
// configuration defaults.
module headlamp_level_servo_core import hlsrv_pkg::*; #(
	parameter int AVG_DEPTH   = 10,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hlsrv_in_if.sink              cmd,
	hlsrv_out_if.source           result,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Only the low SAMPLE_BITS of each reading matter, and a reading never has
	// more bits than its field.
	localparam int SAMPLE_W = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
	localparam int ADDR_W   = $clog2(AVG_DEPTH);
	localparam logic [ADDR_W-1:0]  LAST_SLOT  = ADDR_W'(AVG_DEPTH - 1);
	localparam logic [RETRY_W-1:0] LAST_RETRY = RETRY_W'(RETRY_LIMIT - 1);
	localparam int LANE_REF  = 0;
	localparam int LANE_SENS = 1;
	localparam int LANE_CHK  = 2;
	localparam int LANES     = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_MUL,
		ST_DIV,
		ST_DECIDE,
		ST_CMD,
		ST_RETRY,
		ST_DONE
	} state_t;

	state_t                   state_q;
	opcode_t                  op_q;
	logic [ADDR_W-1:0]        slot_q;
	logic [ADDR_W-1:0]        sweep_q;
	logic [RETRY_W-1:0]       retry_q;
	logic                     full_q;
	cfg_t                     cfg_q;

	logic                     out_valid_q;
	logic [WIPER_W-1:0]       out_wiper_q;
	action_t                  out_action_q;
	logic                     out_full_q;
	logic signed [UOFF_W-1:0] out_uoff_q;
	logic signed [ERR_W-1:0]  out_err_q;

	logic                     accept;
	lane_ctl_t                lane_ctl;
	merge_ctl_t               merge_ctl;
	logic [ADDR_W-1:0]        lane_addr;
	logic [SAMPLE_W-1:0]      lane_sample [LANES];
	logic [SAMPLE_W-1:0]      lane_avg    [LANES];

	logic [WIPER_W-1:0]       m_wiper;
	action_t                  m_action;
	logic signed [UOFF_W-1:0] m_uoff;
	logic signed [ERR_W-1:0]  m_err;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// The tick's readings go into the rings in the transfer cycle; the sweep
	// reads them back afterwards through the same port.
	always_comb begin
		lane_ctl.wr_en   = accept && (cmd.opcode == OP_TICK);
		lane_ctl.rd_en   = (state_q == ST_SWEEP);
		lane_ctl.acc_clr = accept;
		lane_ctl.mul_en  = (state_q == ST_MUL);
		lane_ctl.avg_en  = (state_q == ST_DIV);
		lane_addr        = (state_q == ST_SWEEP) ? sweep_q : slot_q;

		merge_ctl.start  = accept;
		merge_ctl.decide = (state_q == ST_DECIDE);
		merge_ctl.cmd    = (state_q == ST_CMD);
		merge_ctl.retry  = (state_q == ST_RETRY);
		merge_ctl.op     = op_q;
	end

	assign lane_sample[LANE_REF]  = cmd.ref_sample[SAMPLE_W-1:0];
	assign lane_sample[LANE_SENS] = cmd.sensor_sample[SAMPLE_W-1:0];
	assign lane_sample[LANE_CHK]  = cmd.check_sample[SAMPLE_W-1:0];

	// One lane per ADC channel, all driven by the same sequencer controls.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		hlsrv_lane #(
			.AVG_DEPTH (AVG_DEPTH),
			.SAMPLE_W  (SAMPLE_W)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl),
			.addr    (lane_addr),
			.sample  (lane_sample[g]),
			.average (lane_avg[g])
		);
	end

	// The merge stage combines the three averages into the control error and
	// owns the wiper and the user offset.
	hlsrv_merge #(
		.SAMPLE_W (SAMPLE_W)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (merge_ctl),
		.cfg         (cfg_q),
		.ref_avg     (lane_avg[LANE_REF]),
		.sens_avg    (lane_avg[LANE_SENS]),
		.chk_avg     (lane_avg[LANE_CHK]),
		.wiper       (m_wiper),
		.action      (m_action),
		.user_offset (m_uoff),
		.ctrl_err    (m_err)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_HEADROOM_LIMIT: cfg_q.headroom_limit <= cfg_data[9:0];
				CFG_OUTPUT_FLOOR:   cfg_q.output_floor   <= cfg_data[9:0];
				CFG_DEFAULT_OFFSET: cfg_q.default_offset <= $signed(cfg_data[10:0]);
				CFG_DEADBAND:       cfg_q.deadband       <= cfg_data[7:0];
				CFG_OFFSET_STEP:    cfg_q.offset_step    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_TICK;
			slot_q       <= '0;
			sweep_q      <= '0;
			retry_q      <= '0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_wiper_q  <= WIPER_RESET;
			out_action_q <= ACT_NONE;
			out_full_q   <= 1'b0;
			out_uoff_q   <= '0;
			out_err_q    <= '0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= cmd.opcode;
						sweep_q <= '0;
						if (cmd.opcode == OP_TICK) begin
							if (slot_q == LAST_SLOT) begin
								slot_q <= '0;
								full_q <= 1'b1;
							end else begin
								slot_q <= slot_q + ADDR_W'(1);
							end
							// Averages are formed only once every slot holds a reading.
							if (full_q || slot_q == LAST_SLOT) begin
								state_q <= ST_SWEEP;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_CMD;
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
				end
				ST_CMD: begin
					retry_q <= '0;
					if (op_q == OP_RAISE || op_q == OP_LOWER) begin
						state_q <= ST_RETRY;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RETRY: begin
					if (retry_q == LAST_RETRY) begin
						state_q <= ST_DONE;
					end else begin
						retry_q <= retry_q + RETRY_W'(1);
					end
				end
				ST_DONE: begin
					// Load the result once the register is free or being emptied.
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_wiper_q  <= m_wiper;
						out_action_q <= m_action;
						out_full_q   <= full_q;
						out_uoff_q   <= m_uoff;
						out_err_q    <= m_err;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid           = out_valid_q;
	assign result.wiper           = out_wiper_q;
	assign result.wiper_action    = out_action_q;
	assign result.averages_ready  = out_full_q;
	assign result.user_offset_now = out_uoff_q;
	assign result.control_error   = out_err_q;

endmodule

### hw/rtl/hlsrv_checker.sv
`timescale 1ns / 1ps

module hlsrv_checker import hlsrv_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [WIPER_W-1:0] res_wiper,
	input action_t            res_action,
	input logic               res_avg_ready
);

	// One item at a time: the block is busy right after it takes one.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd ready right after a transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_wiper) && $stable(res_action))
		else $error("stalled result changed");

	// The wiper never moves while the rings are still filling.
	a_no_action_filling: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_avg_ready |-> res_action == ACT_NONE)
		else $error("wiper moved before the averages were ready");

	a_inc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == ACT_INC |-> res_wiper != '0)
		else $error("wiper increment wrapped");

	a_dec_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_action == ACT_DEC |-> res_wiper != WIPER_MAX)
		else $error("wiper decrement wrapped");

endmodule

bind headlamp_level_servo_core hlsrv_checker u_hlsrv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_wiper     (result.wiper),
	.res_action    (result.wiper_action),
	.res_avg_ready (result.averages_ready)
);

### sim/tb_headlamp_level_servo_core.sv
`timescale 1ns / 1ps

module tb_headlamp_level_servo_core;
	import hlsrv_pkg::*;

	// The block is built with the ring depth and sample width of the product.
	localparam int RING_DEPTH       = 10;
	localparam int SAMPLE_BITS_USED = 10;
	localparam logic [SAMPLE_FIELD_W-1:0] SAMPLE_MASK =
		SAMPLE_FIELD_W'((1 << SAMPLE_BITS_USED) - 1);
	localparam int SAMPLE_TOP = (1 << SAMPLE_FIELD_W) - 1;

	// The slowest run stays well within this limit: about 680 items of at most one
	// full tick each, plus the longest sender gap and receiver stall.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_LINES = 40;

	// One result transfer as the block should present it.
	typedef struct packed {
		logic [WIPER_W-1:0]       wiper;
		action_t                  action;
		logic                     ring_full;
		logic signed [UOFF_W-1:0] uoff;
		logic signed [ERR_W-1:0]  err;
	} servo_outcome_t;

	// Tracks the servo: it keeps its own copy of the rings, the averages, the
	// user offset, the wiper and the registers, works out the result of every
	// accepted item, and checks result transfers against them in order.
	class servo_tracker;
		int headroom_limit;
		int output_floor;
		int default_offset;
		int deadband;
		int offset_step;

		logic [SAMPLE_FIELD_W-1:0] ref_ring [RING_DEPTH];
		logic [SAMPLE_FIELD_W-1:0] sensor_ring [RING_DEPTH];
		logic [SAMPLE_FIELD_W-1:0] check_ring [RING_DEPTH];
		int write_slot;
		bit ring_full;
		int ref_avg;
		int sensor_avg;
		int check_avg;
		int user_offset;
		int wiper;

		servo_outcome_t awaited [$];

		int ticks;
		int commands;
		int compared;
		int mismatches;
		int wiper_low_hits;
		int wiper_high_hits;
		int settings_loaded;

		function new();
			headroom_limit = int'(CFG_RESET.headroom_limit);
			output_floor   = int'(CFG_RESET.output_floor);
			default_offset = int'(CFG_RESET.default_offset);
			deadband       = int'(CFG_RESET.deadband);
			offset_step    = int'(CFG_RESET.offset_step);
			foreach (ref_ring[i]) begin
				ref_ring[i]    = '0;
				sensor_ring[i] = '0;
				check_ring[i]  = '0;
			end
			write_slot  = 0;
			ring_full   = 1'b0;
			ref_avg     = 0;
			sensor_avg  = 0;
			check_avg   = 0;
			user_offset = 0;
			wiper       = int'(WIPER_RESET);
		endfunction

		function int clamp(int v, int lo, int hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int ring_mean(logic [SAMPLE_FIELD_W-1:0] ring [RING_DEPTH]);
			int sum;
			sum = 0;
			foreach (ring[i])
				sum += int'(ring[i]);
			return sum / RING_DEPTH;
		endfunction

		function int error_now();
			return clamp(sensor_avg - check_avg + default_offset + user_offset,
				int'(ERR_MIN), int'(ERR_MAX));
		endfunction

		function void shift_offset(int delta);
			user_offset = clamp(user_offset + delta, int'(UOFF_MIN), int'(UOFF_MAX));
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_HEADROOM_LIMIT: headroom_limit = int'(d[9:0]);
				CFG_OUTPUT_FLOOR:   output_floor   = int'(d[9:0]);
				CFG_DEFAULT_OFFSET: default_offset = int'($signed(d));
				CFG_DEADBAND:       deadband       = int'(d[7:0]);
				CFG_OFFSET_STEP:    offset_step    = int'(d[7:0]);
				default: ;
			endcase
		endfunction

		function void note_item(opcode_t op, logic [SAMPLE_FIELD_W-1:0] r,
				logic [SAMPLE_FIELD_W-1:0] s, logic [SAMPLE_FIELD_W-1:0] c);
			servo_outcome_t o;
			action_t act;
			int e;
			act = ACT_NONE;
			case (op)
				OP_TICK: begin
					ticks++;
					ref_ring[write_slot]    = r & SAMPLE_MASK;
					sensor_ring[write_slot] = s & SAMPLE_MASK;
					check_ring[write_slot]  = c & SAMPLE_MASK;
					write_slot++;
					if (write_slot >= RING_DEPTH) begin
						ring_full  = 1'b1;
						write_slot = 0;
					end
					// While the rings fill, a tick only stores its readings.
					if (ring_full) begin
						ref_avg    = ring_mean(ref_ring);
						sensor_avg = ring_mean(sensor_ring);
						check_avg  = ring_mean(check_ring);
						e = error_now();
						if (e < 0 && wiper > 0 && check_avg >= output_floor) begin
							if (e < -deadband) begin
								wiper--;
								act = ACT_DEC;
							end
						end else if (e > 0 && wiper < int'(WIPER_MAX) &&
								ref_avg - check_avg >= headroom_limit) begin
							if (e > deadband) begin
								wiper++;
								act = ACT_INC;
							end
						end
					end
				end
				OP_RAISE: begin
					commands++;
					if (ref_avg - check_avg >= headroom_limit) begin
						shift_offset(offset_step);
						if (check_avg - output_floor < offset_step)
							for (int i = 0; i < RETRY_LIMIT && error_now() < 0; i++)
								shift_offset(offset_step);
					end
				end
				OP_LOWER: begin
					commands++;
					if (check_avg >= output_floor) begin
						shift_offset(-offset_step);
						if (ref_avg - check_avg - headroom_limit < offset_step)
							for (int i = 0; i < RETRY_LIMIT && error_now() > 0; i++)
								shift_offset(-offset_step);
					end
				end
				OP_CLEAR: begin
					commands++;
					user_offset = 0;
				end
			endcase
			if (act == ACT_DEC && wiper == 0)
				wiper_low_hits++;
			if (act == ACT_INC && wiper == int'(WIPER_MAX))
				wiper_high_hits++;
			o.wiper     = WIPER_W'(wiper);
			o.action    = act;
			o.ring_full = ring_full;
			o.uoff      = UOFF_W'(user_offset);
			o.err       = ERR_W'(error_now());
			awaited.push_back(o);
		endfunction

		task report(string what);
			if (mismatches < REPORT_LINES)
				$display("[%0t] result %0d: %s", $time, compared, what);
			mismatches++;
		endtask

		task check_outcome(logic [WIPER_W-1:0] wiper_got, action_t action_got,
				logic ready_got, logic signed [UOFF_W-1:0] uoff_got,
				logic signed [ERR_W-1:0] err_got);
			servo_outcome_t o;
			if (awaited.size() == 0) begin
				report($sformatf("result transfer with nothing awaited (wiper %0d)",
					wiper_got));
				return;
			end
			o = awaited.pop_front();
			compared++;
			if (wiper_got !== o.wiper)
				report($sformatf("wiper %0d, awaited %0d", wiper_got, o.wiper));
			if (action_got !== o.action)
				report($sformatf("wiper_action %0d, awaited %0d", action_got, o.action));
			if (ready_got !== o.ring_full)
				report($sformatf("averages_ready %0b, awaited %0b", ready_got, o.ring_full));
			if (uoff_got !== o.uoff)
				report($sformatf("user_offset_now %0d, awaited %0d", uoff_got, o.uoff));
			if (err_got !== o.err)
				report($sformatf("control_error %0d, awaited %0d", err_got, o.err));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hlsrv_in_if  cmd_ch ();
	hlsrv_out_if res_ch ();

	servo_tracker tracker = new();

	// When set, neither side idles: transfers go back to back.
	bit quiet;
	int cycle_count;
	int stall_left;

	headlamp_level_servo_core #(
		.AVG_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS_USED)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.result      (res_ch),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a run that hangs on a handshake ends here as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, tracker.awaited.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Idle lengths for both channels: mostly none, often a few cycles, and
	// now and then a long pause.
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(30, 4);
	endfunction

	// Result side: every transfer is checked at the edge where it happens, and
	// ready is held low for random gaps drawn from pick_gap. Ready stays low
	// through reset.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				tracker.check_outcome(res_ch.wiper, res_ch.wiper_action,
					res_ch.averages_ready, res_ch.user_offset_now, res_ch.control_error);
			if (stall_left == 0)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// A reading near a working point, or now and then anywhere in the range.
	function automatic logic [SAMPLE_FIELD_W-1:0] sample_around(int base, int spread,
			int wild_pct);
		int v;
		if ($urandom_range(99) < wild_pct)
			return SAMPLE_FIELD_W'($urandom);
		v = base + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_TOP)
			v = SAMPLE_TOP;
		return SAMPLE_FIELD_W'(v);
	endfunction

	// Offers one item, after an optional idle gap, and holds it until the
	// block takes the transfer. Returns at the edge of that transfer.
	task automatic send_item(input opcode_t op, input logic [SAMPLE_FIELD_W-1:0] r,
			input logic [SAMPLE_FIELD_W-1:0] s, input logic [SAMPLE_FIELD_W-1:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.opcode        <= op;
		cmd_ch.ref_sample    <= r;
		cmd_ch.sensor_sample <= s;
		cmd_ch.check_sample  <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		tracker.note_item(op, r, s, c);
	endtask

	// Stops offering items and waits until every awaited result has come out.
	// Each item yields exactly one result, so the block is idle afterward.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.awaited.size() != 0);
	endtask

	// Writes all five registers back to back; with poke_beyond it also writes
	// random data to every index past the register list, which must be ignored.
	task automatic load_settings(input int headroom, input int floor_level,
			input int offset, input int band, input int step_size, input bit poke_beyond);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		int last;
		last = poke_beyond ? (1 << CFG_IDX_W) - 1 : int'(CFG_OFFSET_STEP);
		for (int i = 0; i <= last; i++) begin
			idx = CFG_IDX_W'(i);
			case (idx)
				CFG_HEADROOM_LIMIT: data = CFG_DATA_W'(headroom);
				CFG_OUTPUT_FLOOR:   data = CFG_DATA_W'(floor_level);
				CFG_DEFAULT_OFFSET: data = CFG_DATA_W'(offset);
				CFG_DEADBAND:       data = CFG_DATA_W'(band);
				CFG_OFFSET_STEP:    data = CFG_DATA_W'(step_size);
				default:            data = CFG_DATA_W'($urandom);
			endcase
			cfg_write_en <= 1'b1;
			cfg_index    <= idx;
			cfg_data     <= data;
			@(posedge clk);
			tracker.set_register(idx, data);
		end
		cfg_write_en <= 1'b0;
		tracker.settings_loaded++;
	endtask

	// A run of random items around one working point. cmd_pct is the share of
	// offset commands; among them raise_w and lower_w out of ten pick raise and
	// lower, the rest are clears.
	task automatic run_phase(input int count, input int cmd_pct, input int raise_w,
			input int lower_w, input int ref_base, input int sensor_base,
			input int check_base, input int spread, input int wild_pct);
		opcode_t op;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll >= cmd_pct) begin
				op = OP_TICK;
			end else begin
				roll = $urandom_range(9);
				if (roll < raise_w)
					op = OP_RAISE;
				else if (roll < raise_w + lower_w)
					op = OP_LOWER;
				else
					op = OP_CLEAR;
			end
			send_item(op, sample_around(ref_base, spread, wild_pct),
				sample_around(sensor_base, spread, wild_pct),
				sample_around(check_base, spread, wild_pct));
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		cfg_write_en         <= 1'b0;
		cfg_index            <= CFG_HEADROOM_LIMIT;
		cfg_data             <= '0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.opcode        <= OP_TICK;
		cmd_ch.ref_sample    <= '0;
		cmd_ch.sensor_sample <= '0;
		cmd_ch.check_sample  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset all averages are zero, so the headroom and floor
		// tests both fail: raise and lower are blocked, clear still works.
		send_item(OP_RAISE, 10'h3FF, 10'h3FF, 10'h000);
		send_item(OP_LOWER, 10'h000, 10'h000, 10'h3FF);
		send_item(OP_CLEAR, 10'h2AA, 10'h155, 10'h2AA);

		// Fill the rings with extreme and alternating readings. The ninth tick
		// leaves averages_ready low; the tenth sets it and lets the wiper move
		// for the first time, up, since sensor and headroom are both high.
		send_item(OP_TICK, 10'h000, 10'h000, 10'h000);
		send_item(OP_TICK, 10'h3FF, 10'h3FF, 10'h3FF);
		send_item(OP_TICK, 10'h2AA, 10'h155, 10'h2AA);
		send_item(OP_TICK, 10'h155, 10'h2AA, 10'h155);
		repeat (6) send_item(OP_TICK, 10'h3FF, 10'h3FF, 10'h000);

		// Now both commands pass their limits with the reset step size.
		send_item(OP_RAISE, 10'h000, 10'h000, 10'h000);
		send_item(OP_LOWER, 10'h3FF, 10'h3FF, 10'h3FF);

		// Swing the check channel up and the sensor down, so the error shrinks
		// toward zero but stays positive.
		repeat (3) send_item(OP_TICK, 10'h3FF, 10'h000, 10'h3FF);
		settle();

		// A zero step: raise and lower pass their tests but change nothing.
		// The writes past the register list must leave the settings alone.
		load_settings(0, 0, -1023, 0, 0, 1'b1);
		send_item(OP_RAISE, 10'h3FF, 10'h3FF, 10'h3FF);
		send_item(OP_LOWER, 10'h000, 10'h000, 10'h000);
		send_item(OP_TICK, 10'h3FF, 10'h000, 10'h3FF);
		send_item(OP_CLEAR, 10'h000, 10'h3FF, 10'h000);
		settle();

		// Reset values written back, then wide random traffic so that every
		// bit of every reading toggles and all four operations mix.
		load_settings(int'(CFG_RESET.headroom_limit), int'(CFG_RESET.output_floor),
			int'(CFG_RESET.default_offset), int'(CFG_RESET.deadband),
			int'(CFG_RESET.offset_step), 1'b1);
		run_phase(60, 30, 4, 4, 600, 500, 300, 300, 40);
		settle();

		// Drive the wiper down to its low end and hold it there: the sensor sits
		// far below check, no deadband, smallest nonzero step. Raise is blocked by the
		// highest headroom limit. Both sides run without idling here.
		load_settings(1023, 0, -1023, 0, 1, 1'b0);
		quiet = 1'b1;
		run_phase(210, 8, 2, 6, 800, 100, 700, 40, 0);
		settle();
		quiet = 1'b0;

		// Drive it all the way up to its high end against the widest deadband.
		// Lower is blocked by the highest output floor.
		load_settings(0, 1023, 1023, 255, 60, 1'b0);
		run_phase(290, 6, 4, 4, 1000, 950, 100, 20, 0);
		settle();

		// Largest step with mostly raises: the user offset saturates high.
		load_settings(0, 0, 1023, $urandom_range(255), 255, 1'b1);
		run_phase(45, 60, 8, 1, 1000, 500, 200, 150, 20);
		settle();

		// Mostly lowers on fully random readings: it saturates low as well.
		load_settings($urandom_range(1023), 0, -1023, $urandom_range(255), 255, 1'b0);
		run_phase(45, 60, 1, 8, 512, 512, 512, 0, 100);
		settle();

		// Any stray result would show up within one full tick time.
		repeat (RING_DEPTH + 8) @(posedge clk);

		$display("Ran %0d sample ticks and %0d offset commands under %0d register settings,",
			tracker.ticks, tracker.commands, tracker.settings_loaded);
		$display("checked %0d results (wiper hit its low end %0d and high end %0d times).",
			tracker.compared, tracker.wiper_low_hits, tracker.wiper_high_hits);
		if (tracker.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches found.", tracker.mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
